>>> rtl/nspp_pkg.sv
// ----------------------------------------------------------------------------
// nspp_pkg
// Shared types, character codes and tables for the note-string parser.
// ----------------------------------------------------------------------------
package nspp_pkg;

    // Timer clock that the tone divider counts from.
    localparam int unsigned TIMER_BASE_HZ = 62500;

    localparam int unsigned NOTE_COUNT   = 24;
    localparam int unsigned NOTE_IDX_W   = $clog2(NOTE_COUNT);
    localparam int unsigned SEMI_STEP    = 12;
    localparam int unsigned GAP_MS_VALUE = 30;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned TEMPO_W    = 6;
    localparam int unsigned CMD_W      = 2;
    localparam int unsigned FREQ_W     = 11;
    localparam int unsigned DIVIDER_W  = 8;
    localparam int unsigned DURATION_W = 10;
    localparam int unsigned GAP_W      = 5;
    localparam int unsigned MULT_W     = 5;

    localparam logic [TEMPO_W-1:0] TEMPO_RESET = TEMPO_W'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_SET_TONE  = 2'd0,
        CMD_HOLD      = 2'd1,
        CMD_OUT_RANGE = 2'd2
    } cmd_t;

    // Characters with a meaning of their own
    localparam logic [BYTE_W-1:0] CH_END   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;  // '-'

    localparam logic [FREQ_W-1:0] FREQ_TABLE [NOTE_COUNT] = '{
        11'd523,  11'd555,  11'd587,  11'd623,  11'd659,  11'd699,
        11'd740,  11'd784,  11'd831,  11'd881,  11'd933,  11'd988,
        11'd1047, 11'd1109, 11'd1175, 11'd1245, 11'd1318, 11'd1397,
        11'd1480, 11'd1568, 11'd1661, 11'd1760, 11'd1865, 11'd1975
    };

    typedef struct packed {
        logic       hit;
        logic [3:0] semi;
    } note_lookup_t;

    typedef struct packed {
        logic                  valid;
        cmd_t                  command;
        logic [FREQ_W-1:0]     tone_freq_hz;
        logic [DIVIDER_W-1:0]  timer_divider;
        logic [DURATION_W-1:0] duration_units;
        logic [GAP_W-1:0]      gap_ms;
    } nspp_result_t;

    function automatic note_lookup_t semitone_of(input logic [BYTE_W-1:0] ch);
        note_lookup_t r;
        r.hit  = 1'b1;
        r.semi = 4'd0;
        unique case (ch)
            8'h63:   r.semi = 4'd0;   // c
            8'h43:   r.semi = 4'd1;   // C
            8'h64:   r.semi = 4'd2;   // d
            8'h44:   r.semi = 4'd3;   // D
            8'h65:   r.semi = 4'd4;   // e
            8'h66:   r.semi = 4'd5;   // f
            8'h46:   r.semi = 4'd6;   // F
            8'h67:   r.semi = 4'd7;   // g
            8'h47:   r.semi = 4'd8;   // G
            8'h61:   r.semi = 4'd9;   // a
            8'h41:   r.semi = 4'd10;  // A
            8'h68:   r.semi = 4'd11;  // h
            default: r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    // Zero means the byte is not a duration digit.
    function automatic logic [MULT_W-1:0] multiplier_of(input logic [BYTE_W-1:0] ch);
        logic [MULT_W-1:0] m;
        unique case (ch)
            8'h31:   m = 5'd16;  // '1'
            8'h32:   m = 5'd8;   // '2'
            8'h33:   m = 5'd6;   // '3'
            8'h34:   m = 5'd4;   // '4'
            8'h35:   m = 5'd3;   // '5'
            8'h38:   m = 5'd2;   // '8'
            default: m = 5'd0;
        endcase
        return m;
    endfunction

endpackage

>>> rtl/nspp_decode.sv
// ----------------------------------------------------------------------------
// nspp_decode
// Single-pass decode of one string byte: octave update, note lookup with
// divider ROM, and duration computation.
// ----------------------------------------------------------------------------
module nspp_decode
    import nspp_pkg::*;
(
    input  logic [BYTE_W-1:0]  symbol_byte,
    input  logic [BYTE_W-1:0]  octave,
    input  logic [TEMPO_W-1:0] tempo,
    output logic [BYTE_W-1:0]  octave_next,
    output nspp_result_t       result
);

    logic [DIVIDER_W-1:0] div_rom [NOTE_COUNT];

    // Divider = base/freq - 1, worked out at elaboration.
    for (genvar i = 0; i < NOTE_COUNT; i++) begin : g_div
        localparam int unsigned Q = TIMER_BASE_HZ / FREQ_TABLE[i];
        assign div_rom[i] = (Q == 0) ? '0 : DIVIDER_W'(Q - 1);
    end

    note_lookup_t           note;
    logic [MULT_W-1:0]      mult;
    logic signed [BYTE_W:0] note_idx;
    logic                   in_range;
    logic [NOTE_IDX_W-1:0]  rom_addr;
    logic [MULT_W+TEMPO_W-1:0] product;

    assign note     = semitone_of(symbol_byte);
    assign mult     = multiplier_of(symbol_byte);
    assign note_idx = $signed({octave[BYTE_W-1], octave}) + $signed({5'b0, note.semi});
    assign in_range = !note_idx[BYTE_W] && (note_idx[BYTE_W-1:0] < BYTE_W'(NOTE_COUNT));
    assign rom_addr = note_idx[NOTE_IDX_W-1:0];
    assign product  = (MULT_W+TEMPO_W)'(mult) * (MULT_W+TEMPO_W)'(tempo);

    always_comb begin
        octave_next = octave;
        result      = '0;
        priority if (symbol_byte == CH_END) begin
            octave_next = '0;
        end else if (symbol_byte == CH_PLUS) begin
            octave_next = octave + BYTE_W'(SEMI_STEP);
        end else if (symbol_byte == CH_MINUS) begin
            octave_next = octave - BYTE_W'(SEMI_STEP);
        end else if (note.hit) begin
            result.valid = 1'b1;
            if (in_range) begin
                result.command       = CMD_SET_TONE;
                result.tone_freq_hz  = FREQ_TABLE[rom_addr];
                result.timer_divider = div_rom[rom_addr];
            end else begin
                result.command = CMD_OUT_RANGE;
            end
        end else if (mult != '0) begin
            result.valid          = 1'b1;
            result.command        = CMD_HOLD;
            result.duration_units = product[DURATION_W-1:0];
            result.gap_ms         = GAP_W'(GAP_MS_VALUE);
        end else begin
            result = '0;
        end
    end

endmodule

>>> rtl/note_string_player_parser_core.sv
// ----------------------------------------------------------------------------
// note_string_player_parser_core
// Parses a note string one byte per beat into tone and duration commands.
// ----------------------------------------------------------------------------
// One byte is taken per clock. The byte is decoded against the current octave
// offset in a single pass, and any result lands in the output register. A new
// byte can enter in the same cycle that the parked result is taken, so a
// waiting result holds off the input only while m_ready is low. Throughput is
// one byte per cycle unless stalled; each registered result shows in the cycle after
// its byte. The only stall is a full output register that the consumer is not
// draining. '+', '-' and end of string set the octave only; unknown bytes do nothing.
module note_string_player_parser_core
    import nspp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [TEMPO_W-1:0]    cfg_wr_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [BYTE_W-1:0]     s_symbol_byte,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CMD_W-1:0]      m_command,
    output logic [FREQ_W-1:0]     m_tone_freq_hz,
    output logic [DIVIDER_W-1:0]  m_timer_divider,
    output logic [DURATION_W-1:0] m_duration_units,
    output logic [GAP_W-1:0]      m_gap_ms
);

    logic [TEMPO_W-1:0] tempo_reg;
    logic [BYTE_W-1:0]  octave_reg;
    logic [BYTE_W-1:0]  octave_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    nspp_result_t       out_reg;
    nspp_result_t       dec_result;
    logic               s_beat;

    nspp_decode u_decode (
        .symbol_byte (s_symbol_byte),
        .octave      (octave_reg),
        .tempo       (tempo_reg),
        .octave_next (octave_next),
        .result      (dec_result)
    );

    assign s_ready = !out_valid_reg || m_ready;
    assign s_beat  = s_valid && s_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (s_beat) begin
            out_valid_next = dec_result.valid;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tempo_reg     <= TEMPO_RESET;
            octave_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                tempo_reg <= cfg_wr_data;
            end
            if (s_beat) begin
                octave_reg <= octave_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat && dec_result.valid) begin
            out_reg <= dec_result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_command        = out_reg.command;
    assign m_tone_freq_hz   = out_reg.tone_freq_hz;
    assign m_timer_divider  = out_reg.timer_divider;
    assign m_duration_units = out_reg.duration_units;
    assign m_gap_ms         = out_reg.gap_ms;

    // Backpressure only when a result is parked and not taken.
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (out_valid_reg && !m_ready))
        else $error("s_ready low without a stalled result");

    a_end_clears_octave: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_beat && s_symbol_byte == CH_END) |=> (octave_reg == '0))
        else $error("end of string did not clear octave offset");

    a_plus_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_beat && s_symbol_byte == CH_PLUS)
            |=> (octave_reg == $past(octave_reg) + BYTE_W'(SEMI_STEP)))
        else $error("octave up step wrong");

    a_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_command == CMD_OUT_RANGE)
            |-> (m_tone_freq_hz == '0 && m_timer_divider == '0 &&
                 m_duration_units == '0 && m_gap_ms == '0))
        else $error("out-of-range result carries payload");

    a_tone_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_command == CMD_SET_TONE)
            |-> (m_tone_freq_hz != '0 && m_duration_units == '0 && m_gap_ms == '0))
        else $error("set-tone result malformed");

endmodule

>>> sim/note_string_player_parser_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// note_string_player_parser_core_tb
// Streams note-string bytes through the parser under random back-pressure and
// compares every command beat against a local decoder of the same notation.
// ----------------------------------------------------------------------------
module note_string_player_parser_core_tb;
    import nspp_pkg::*;

    localparam int unsigned TONE_CLK_HZ = 62500;
    localparam int unsigned HOLD_GAP_MS = 30;
    localparam int unsigned OCTAVE_STEP = 12;
    localparam int unsigned IDLE_PCT    = 28;
    localparam int unsigned RX_HOLD_CYC = 300;
    localparam int unsigned MAX_REPORTS = 40;

    localparam logic [FREQ_W-1:0] PITCH_HZ [24] = '{
        11'd523,  11'd555,  11'd587,  11'd623,  11'd659,  11'd699,
        11'd740,  11'd784,  11'd831,  11'd881,  11'd933,  11'd988,
        11'd1047, 11'd1109, 11'd1175, 11'd1245, 11'd1318, 11'd1397,
        11'd1480, 11'd1568, 11'd1661, 11'd1760, 11'd1865, 11'd1975
    };

    localparam logic [7:0] NOTE_CHARS [12] = '{
        "c", "C", "d", "D", "e", "f", "F", "g", "G", "a", "A", "h"
    };
    localparam logic [7:0] LEN_CHARS [6] = '{"1", "2", "3", "4", "5", "8"};

    typedef struct {
        logic                  produced;
        cmd_t                  command;
        logic [FREQ_W-1:0]     tone_freq_hz;
        logic [DIVIDER_W-1:0]  timer_divider;
        logic [DURATION_W-1:0] duration_units;
        logic [GAP_W-1:0]      gap_ms;
    } tone_cmd_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [TEMPO_W-1:0]    cfg_wr_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_symbol_byte = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CMD_W-1:0]      m_command;
    logic [FREQ_W-1:0]     m_tone_freq_hz;
    logic [DIVIDER_W-1:0]  m_timer_divider;
    logic [DURATION_W-1:0] m_duration_units;
    logic [GAP_W-1:0]      m_gap_ms;

    logic [BYTE_W-1:0] symbols_to_send [$];
    tone_cmd_t         tone_cmds_due [$];

    logic [7:0]         octave_model;
    logic [TEMPO_W-1:0] tempo_model;
    logic               symbol_taken = 1'b0;
    int                 mismatch_count = 0;

    bit no_gaps = 1'b0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    logic [7:0] gen_octave = '0;

    note_string_player_parser_core u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_symbol_byte    (s_symbol_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_command        (m_command),
        .m_tone_freq_hz   (m_tone_freq_hz),
        .m_timer_divider  (m_timer_divider),
        .m_duration_units (m_duration_units),
        .m_gap_ms         (m_gap_ms)
    );

    always #5 aclk = ~aclk;

    // Decodes one byte against the running octave offset.
    function automatic tone_cmd_t decode_symbol(input logic [7:0] ch);
        tone_cmd_t   r;
        int          semi;
        int          note_idx;
        int unsigned mult;
        int unsigned quot;
        r.produced       = 1'b0;
        r.command        = CMD_SET_TONE;
        r.tone_freq_hz   = '0;
        r.timer_divider  = '0;
        r.duration_units = '0;
        r.gap_ms         = '0;
        semi = -1;
        mult = 0;
        for (int i = 0; i < 12; i++)
            if (NOTE_CHARS[i] == ch) semi = i;
        case (ch)
            "1": mult = 16;
            "2": mult = 8;
            "3": mult = 6;
            "4": mult = 4;
            "5": mult = 3;
            "8": mult = 2;
            default: mult = 0;
        endcase
        if (ch == CH_END) begin
            octave_model = '0;
        end else if (ch == CH_PLUS) begin
            octave_model = octave_model + 8'(OCTAVE_STEP);
        end else if (ch == CH_MINUS) begin
            octave_model = octave_model - 8'(OCTAVE_STEP);
        end else if (semi >= 0) begin
            r.produced = 1'b1;
            note_idx = int'($signed(octave_model)) + semi;
            if (note_idx < 0 || note_idx > 23) begin
                r.command = CMD_OUT_RANGE;
            end else begin
                r.tone_freq_hz = PITCH_HZ[note_idx];
                quot = TONE_CLK_HZ / r.tone_freq_hz;
                r.timer_divider = (quot == 0) ? '0 : DIVIDER_W'(quot - 1);
            end
        end else if (mult != 0) begin
            r.produced       = 1'b1;
            r.command        = CMD_HOLD;
            r.duration_units = DURATION_W'(mult * tempo_model);
            r.gap_ms         = GAP_W'(HOLD_GAP_MS);
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t ERROR %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // Input beat driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || symbol_taken) begin
            if (symbols_to_send.size() > 0 &&
                (no_gaps || $urandom_range(0, 99) >= IDLE_PCT)) begin
                s_valid       <= 1'b1;
                s_symbol_byte <= symbols_to_send.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result-side ready, with long hold-offs on request
    always @(negedge aclk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = RX_HOLD_CYC;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Monitor: predicts on input beats, checks output beats
    always @(posedge aclk) begin
        tone_cmd_t exp_cmd;
        tone_cmd_t got_cmd;
        if (!aresetn) begin
            octave_model = '0;
            tempo_model  = TEMPO_W'(1);
            symbol_taken = 1'b0;
        end else begin
            if (cfg_wr_en) tempo_model = cfg_wr_data;
            symbol_taken = s_valid && s_ready;
            if (symbol_taken) begin
                got_cmd = decode_symbol(s_symbol_byte);
                if (got_cmd.produced) tone_cmds_due.push_back(got_cmd);
            end
            if (m_valid && m_ready) begin
                if (tone_cmds_due.size() == 0) begin
                    flag_mismatch("result beat with nothing pending, command", m_command, -1);
                end else begin
                    exp_cmd = tone_cmds_due.pop_front();
                    if (m_command !== exp_cmd.command)
                        flag_mismatch("command", m_command, exp_cmd.command);
                    if (m_tone_freq_hz !== exp_cmd.tone_freq_hz)
                        flag_mismatch("tone_freq_hz", m_tone_freq_hz, exp_cmd.tone_freq_hz);
                    if (m_timer_divider !== exp_cmd.timer_divider)
                        flag_mismatch("timer_divider", m_timer_divider,
                                      exp_cmd.timer_divider);
                    if (m_duration_units !== exp_cmd.duration_units)
                        flag_mismatch("duration_units", m_duration_units,
                                      exp_cmd.duration_units);
                    if (m_gap_ms !== exp_cmd.gap_ms)
                        flag_mismatch("gap_ms", m_gap_ms, exp_cmd.gap_ms);
                end
            end
        end
    end

    // Wait until every byte went in and every command came out.
    task automatic drain_all();
        while (symbols_to_send.size() != 0 || s_valid || tone_cmds_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_tempo(input logic [TEMPO_W-1:0] value);
        drain_all();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly well-formed melody text; offset kept near the table range.
    // The count is in bytes, octave runs included.
    task automatic queue_melody(input int count);
        int         pick;
        int         run_len;
        int         pushed;
        logic [7:0] ch;
        pushed = 0;
        while (pushed < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                ch = NOTE_CHARS[$urandom_range(0, 11)];
            end else if (pick < 70) begin
                ch = LEN_CHARS[$urandom_range(0, 5)];
            end else if (pick < 84) begin
                if ($signed(gen_octave) >= 12)
                    ch = ($urandom_range(0, 99) < 80) ? CH_MINUS : CH_PLUS;
                else if ($signed(gen_octave) <= 0)
                    ch = ($urandom_range(0, 99) < 80) ? CH_PLUS : CH_MINUS;
                else
                    ch = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
            end else if (pick < 89) begin
                ch = CH_END;
            end else if (pick < 97) begin
                ch = BYTE_W'($urandom_range(0, 255));
            end else begin
                // long octave run so the offset wraps around
                run_len = $urandom_range(18, 24);
                ch = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
                for (int k = 0; k < run_len - 1; k++) begin
                    symbols_to_send.push_back(ch);
                    gen_octave = (ch == CH_PLUS) ? gen_octave + 8'd12 : gen_octave - 8'd12;
                    pushed++;
                end
            end
            if (ch == CH_END) gen_octave = '0;
            else if (ch == CH_PLUS) gen_octave = gen_octave + 8'd12;
            else if (ch == CH_MINUS) gen_octave = gen_octave - 8'd12;
            symbols_to_send.push_back(ch);
            pushed++;
        end
    endtask

    initial begin
        logic [7:0] directed [$];
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: table edges, out of range both ways, all lengths, junk
        directed = '{"c", "h", CH_PLUS, "h", "c", CH_PLUS, "c", CH_END,
                     CH_MINUS, "h", CH_PLUS, "C", "1", "2", "3", "4", "5", "8",
                     "0", "9", 8'hFF, 8'h80, "A", CH_END};
        foreach (directed[i]) symbols_to_send.push_back(directed[i]);

        write_tempo(6'd63);
        // receiver stalls while the sender keeps offering
        hold_requests++;
        queue_melody(80);
        queue_melody(150);

        write_tempo(6'd0);
        no_gaps = 1'b1;
        queue_melody(200);
        drain_all();
        no_gaps = 1'b0;
        queue_melody(50);

        write_tempo(TEMPO_W'($urandom_range(2, 62)));
        queue_melody(230);

        write_tempo(TEMPO_W'($urandom_range(0, 63)));
        hold_requests++;
        queue_melody(230);

        write_tempo(6'd1);
        queue_melody(200);

        write_tempo(TEMPO_W'($urandom_range(0, 63)));
        queue_melody(200);

        drain_all();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
